// ----- rtl/core/rc4_pkg.sv -----
// Shared types and constants for the RC4 stream cipher engine.
// No dependencies; used by rc4_engine and rc4_stream_cipher.
package rc4_pkg;

    localparam int KEY_BYTES_DEF = 16;
    localparam int KEY_REG_W     = 64;
    localparam int KEY_W         = 2 * KEY_REG_W;
    localparam int CFG_IDX_W     = 1;
    localparam int BYTE_W        = 8;

    // Operation codes carried by a request
    localparam logic OP_SCHEDULE = 1'b0;
    localparam logic OP_DATA     = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b1;

    // Control from the top level to the engine
    typedef struct packed {
        logic start;
        logic schedule;
    } rc4_ctrl_t;

    // Status from the engine back to the top level
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [BYTE_W-1:0] keystream;
    } rc4_stat_t;

endpackage

// ----- rtl/core/rc4_engine.sv -----
// RC4 permutation memory with the key schedule and keystream sequencer.
// Depends on rc4_pkg.
module rc4_engine #(
    parameter int KEY_BYTES = rc4_pkg::KEY_BYTES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [rc4_pkg::KEY_W-1:0]  key,
    input  rc4_pkg::rc4_ctrl_t         ctrl,
    output rc4_pkg::rc4_stat_t         stat
);

    localparam int KIDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam logic [KIDX_W-1:0] KIDX_LAST = KIDX_W'(KEY_BYTES - 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_FILL = 4'd1;
    localparam logic [3:0] S_K_RN = 4'd2;
    localparam logic [3:0] S_K_SN = 4'd3;
    localparam logic [3:0] S_K_SJ = 4'd4;
    localparam logic [3:0] S_K_WJ = 4'd5;
    localparam logic [3:0] S_D_SI = 4'd6;
    localparam logic [3:0] S_D_SJ = 4'd7;
    localparam logic [3:0] S_D_WJ = 4'd8;
    localparam logic [3:0] S_D_RT = 4'd9;
    localparam logic [3:0] S_D_KS = 4'd10;

    logic [3:0]        state_reg, state_next;
    logic [7:0]        n_reg, n_next;
    logic [KIDX_W-1:0] kidx_reg, kidx_next;
    logic [7:0]        i_reg, i_next;
    logic [7:0]        j_reg, j_next;
    logic [7:0]        si_reg, si_next;
    logic [7:0]        sj_reg, sj_next;
    logic [7:0]        ks_reg, ks_next;
    logic              keyed_reg, keyed_next;
    logic              done_reg, done_next;

    logic [7:0]        mem [256];
    logic [7:0]        rdata_reg;
    logic [7:0]        raddr;
    logic [7:0]        waddr;
    logic [7:0]        wdata;
    logic              we;
    logic [3:0]        kbyte;
    logic [7:0]        key_byte;

    // Select the key byte for the current schedule step
    assign kbyte    = 4'(kidx_reg);
    assign key_byte = key[{kbyte, 3'b000} +: 8];

    // Permutation memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        kidx_next  = kidx_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        si_next    = si_reg;
        sj_next    = sj_reg;
        ks_next    = ks_reg;
        keyed_next = keyed_reg;
        done_next  = 1'b0;
        raddr      = i_reg;
        we         = 1'b0;
        waddr      = n_reg;
        wdata      = n_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (ctrl.start)
                begin
                    if (ctrl.schedule)
                    begin
                        n_next     = 8'd0;
                        kidx_next  = '0;
                        j_next     = 8'd0;
                        state_next = S_FILL;
                    end
                    else if (keyed_reg)
                    begin
                        i_next     = i_reg + 8'd1;
                        raddr      = i_reg + 8'd1;
                        state_next = S_D_SI;
                    end
                    else
                    begin
                        // Unkeyed: pass the byte through
                        ks_next   = 8'd0;
                        done_next = 1'b1;
                    end
                end
            end
            // Write the identity permutation
            S_FILL:
            begin
                we     = 1'b1;
                waddr  = n_reg;
                wdata  = n_reg;
                n_next = n_reg + 8'd1;
                if (n_reg == 8'hFF)
                begin
                    state_next = S_K_RN;
                end
            end
            S_K_RN:
            begin
                raddr      = n_reg;
                state_next = S_K_SN;
            end
            // Take S[n], step j and fetch S[j]
            S_K_SN:
            begin
                si_next    = rdata_reg;
                j_next     = j_reg + rdata_reg + key_byte;
                raddr      = j_reg + rdata_reg + key_byte;
                state_next = S_K_SJ;
            end
            S_K_SJ:
            begin
                we         = 1'b1;
                waddr      = n_reg;
                wdata      = rdata_reg;
                state_next = S_K_WJ;
            end
            S_K_WJ:
            begin
                we        = 1'b1;
                waddr     = j_reg;
                wdata     = si_reg;
                n_next    = n_reg + 8'd1;
                kidx_next = (kidx_reg == KIDX_LAST) ? '0 : kidx_reg + 1'b1;
                if (n_reg == 8'hFF)
                begin
                    i_next     = 8'd0;
                    j_next     = 8'd0;
                    keyed_next = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_K_RN;
                end
            end
            // Keystream: take S[i], step j and fetch S[j]
            S_D_SI:
            begin
                si_next    = rdata_reg;
                j_next     = j_reg + rdata_reg;
                raddr      = j_reg + rdata_reg;
                state_next = S_D_SJ;
            end
            S_D_SJ:
            begin
                sj_next    = rdata_reg;
                we         = 1'b1;
                waddr      = i_reg;
                wdata      = rdata_reg;
                state_next = S_D_WJ;
            end
            S_D_WJ:
            begin
                we         = 1'b1;
                waddr      = j_reg;
                wdata      = si_reg;
                state_next = S_D_RT;
            end
            S_D_RT:
            begin
                raddr      = si_reg + sj_reg;
                state_next = S_D_KS;
            end
            S_D_KS:
            begin
                ks_next    = rdata_reg;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg     <= 8'd0;
            j_reg     <= 8'd0;
            keyed_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            keyed_reg <= keyed_next;
            done_reg  <= done_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        kidx_reg <= kidx_next;
        si_reg   <= si_next;
        sj_reg   <= sj_next;
        ks_reg   <= ks_next;
    end

    assign stat.busy      = (state_reg != S_IDLE) || done_reg;
    assign stat.done      = done_reg;
    assign stat.keystream = ks_reg;

    // Once keyed, stay keyed
    a_keyed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        keyed_reg |=> keyed_reg)
        else $error("keyed flag dropped");

    // Completion lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done held for more than one cycle");

    // Requests arrive only when idle
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> (state_reg == S_IDLE) && !done_reg)
        else $error("request while engine busy");

    // The schedule leaves both indices cleared
    a_sched_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_K_WJ) && (n_reg == 8'hFF) |=> (i_reg == 8'd0) && (j_reg == 8'd0))
        else $error("indices not cleared after schedule");

endmodule

// ----- rtl/core/rc4_stream_cipher.sv -----
// RC4 stream cipher, one direction: key registers, request capture, result register.
// Depends on rc4_pkg and rc4_engine.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+--------------------------------------
//   in       | in_valid / in_stall (out) | operation, data_in, end_of_message
//   out      | out_valid / out_stall (in)| data_out, end_of_message_res
//   config   | cfg_write                 | cfg_index, cfg_data
//
// A data request takes five memory steps per byte, on a memory with one read and
// one write port: read S[i], read S[j], write S[i], write S[j], read S[t]. An
// unkeyed request passes its byte through. A rekey fills the identity permutation,
// then mixes each entry n: read S[n], read S[j], write both back. Reset clears indices,
// keyed flag and key registers; the permutation is undefined until the first rekey. A
// stalled result waits in the output register while the next request is worked on.
module rc4_stream_cipher #(
    parameter int KEY_BYTES = rc4_pkg::KEY_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [rc4_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rc4_pkg::KEY_REG_W-1:0]   cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            operation,
    input  logic [7:0]                      data_in,
    input  logic                            end_of_message,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [7:0]                      data_out,
    output logic                            end_of_message_res
);

    logic [rc4_pkg::KEY_REG_W-1:0] key_low_reg;
    logic [rc4_pkg::KEY_REG_W-1:0] key_high_reg;
    logic                          op_reg;
    logic [7:0]                    data_reg;
    logic                          eom_reg;
    logic                          pend_reg;
    logic [7:0]                    pend_data_reg;
    logic                          out_valid_reg;
    logic [7:0]                    out_data_reg;
    logic                          out_eom_reg;
    logic                          accept;
    logic                          out_free;
    rc4_pkg::rc4_ctrl_t            ctrl;
    rc4_pkg::rc4_stat_t            stat;

    assign in_stall = stat.busy || pend_reg;
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign ctrl.start    = accept;
    assign ctrl.schedule = (operation == rc4_pkg::OP_SCHEDULE);

    rc4_engine #(
        .KEY_BYTES (KEY_BYTES)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .key   ({key_high_reg, key_low_reg}),
        .ctrl  (ctrl),
        .stat  (stat)
    );

    // Key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rc4_pkg::REG_KEY_LOW:  key_low_reg  <= cfg_data;
                rc4_pkg::REG_KEY_HIGH: key_high_reg <= cfg_data;
                default:               key_low_reg  <= key_low_reg;
            endcase
        end
    end

    // Capture the request payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= operation;
            data_reg <= data_in;
            eom_reg  <= end_of_message;
        end
        if (stat.done)
        begin
            pend_data_reg <= data_reg ^ stat.keystream;
        end
        if (pend_reg && out_free)
        begin
            out_data_reg <= pend_data_reg;
            out_eom_reg  <= eom_reg;
        end
    end

    // Hold a finished result, then move it to the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (stat.done && (op_reg == rc4_pkg::OP_DATA))
            begin
                pend_reg <= 1'b1;
            end
            else if (pend_reg && out_free)
            begin
                pend_reg <= 1'b0;
            end

            if (pend_reg && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid          = out_valid_reg;
    assign data_out           = out_data_reg;
    assign end_of_message_res = out_eom_reg;

    // A finished data request always leaves a pending result
    a_done_pend: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done && (op_reg == rc4_pkg::OP_DATA) |=> pend_reg)
        else $error("data result lost");

    // A rekey gives no result
    a_sched_silent: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done && (op_reg == rc4_pkg::OP_SCHEDULE) && !pend_reg |=> !pend_reg)
        else $error("result raised for a rekey");

    // A pending result is not dropped while the output is blocked
    a_pend_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg && out_valid_reg && out_stall |=> pend_reg)
        else $error("pending result dropped");

endmodule

// ----- sim/rc4_stream_cipher_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for rc4_stream_cipher: directed and random requests, both ends idle.
// Depends on rc4_pkg and rc4_stream_cipher; holds its own RC4 predictor for the checks.
module rc4_stream_cipher_tb;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 12;
    localparam int SCHEDULE_QUIET = 2000;   // long enough for one key schedule to finish
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 10000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_REQS     = 155;

    typedef struct packed {
        logic                       op;
        logic [rc4_pkg::BYTE_W-1:0] data;
        logic                       eom;
        logic                       wait_drain;   // hold the request until every result is back
    } cipher_req_t;

    typedef struct packed {
        logic [rc4_pkg::BYTE_W-1:0] data;
        logic                       eom;
    } cipher_res_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_write;
    logic [rc4_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [rc4_pkg::KEY_REG_W-1:0] cfg_data;
    logic                          in_valid;
    logic                          in_stall;
    logic                          operation;
    logic [7:0]                    data_in;
    logic                          end_of_message;
    logic                          out_valid;
    logic                          out_stall;
    logic [7:0]                    data_out;
    logic                          end_of_message_res;

    cipher_req_t pending_reqs[$];
    cipher_res_t expected_bytes[$];

    // Predictor state
    logic [7:0]                    perm [256];
    logic [7:0]                    idx_i;
    logic [7:0]                    idx_j;
    logic                          keyed;
    logic [rc4_pkg::KEY_REG_W-1:0] key_lo_m;
    logic [rc4_pkg::KEY_REG_W-1:0] key_hi_m;

    // Sender and receiver state
    cipher_req_t cur_req;
    logic        have_cur = 1'b0;
    int          tx_gap = 0;
    logic        tx_burst = 1'b0;
    int          reqs_taken = 0;
    cipher_res_t rx_exp;
    int          rx_wait = 0;
    int          rx_hold = 0;
    logic        rx_burst = 1'b0;
    int          results_seen = 0;
    int          errors = 0;
    int          idle_cycles = 0;

    rc4_stream_cipher u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .operation          (operation),
        .data_in            (data_in),
        .end_of_message     (end_of_message),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .data_out           (data_out),
        .end_of_message_res (end_of_message_res)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Pick key byte n, wrapping over the key length
    function automatic logic [7:0] key_byte_at(int n);
        int b;
        b = n % rc4_pkg::KEY_BYTES_DEF;
        if (b < 8)
            return key_lo_m[8 * b +: 8];
        return key_hi_m[8 * (b - 8) +: 8];
    endfunction

    // Run the key schedule over the current key copy
    function automatic void schedule_key();
        logic [7:0] j;
        logic [7:0] t;
        j = 8'd0;
        for (int n = 0; n < 256; n++)
            perm[n[7:0]] = n[7:0];
        for (int n = 0; n < 256; n++)
        begin
            j            = j + perm[n[7:0]] + key_byte_at(n);
            t            = perm[n[7:0]];
            perm[n[7:0]] = perm[j];
            perm[j]      = t;
        end
        idx_i = 8'd0;
        idx_j = 8'd0;
        keyed = 1'b1;
    endfunction

    // Advance the generator by one byte
    function automatic logic [7:0] next_keystream_byte();
        logic [7:0] t;
        logic [7:0] s;
        idx_i       = idx_i + 8'd1;
        idx_j       = idx_j + perm[idx_i];
        t           = perm[idx_i];
        perm[idx_i] = perm[idx_j];
        perm[idx_j] = t;
        s           = perm[idx_i] + perm[idx_j];
        return perm[s];
    endfunction

    // Update the predictor for one accepted request
    function automatic void apply_request(logic op, logic [7:0] data, logic eom);
        cipher_res_t res;
        if (op == rc4_pkg::OP_SCHEDULE)
            schedule_key();
        else
        begin
            res.data = keyed ? (data ^ next_keystream_byte()) : data;
            res.eom  = eom;
            expected_bytes.push_back(res);
        end
    endfunction

    task automatic push_req(logic op, logic [7:0] data, logic eom, logic drain);
        cipher_req_t r;
        r.op         = op;
        r.data       = data;
        r.eom        = eom;
        r.wait_drain = drain;
        pending_reqs.push_back(r);
    endtask

    task automatic write_key(logic [rc4_pkg::CFG_IDX_W-1:0] idx,
                             logic [rc4_pkg::KEY_REG_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == rc4_pkg::REG_KEY_LOW)
            key_lo_m = val;
        else
            key_hi_m = val;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Wait for all requests and results, then let a key schedule finish
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || have_cur || expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SCHEDULE_QUIET) @(posedge clk);
    endtask

    // Sender: predict on acceptance and draw the gap to the next request
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            apply_request(operation, data_in, end_of_message);
            have_cur = 1'b0;
            reqs_taken++;
            if (reqs_taken % 50 == 0)
                tx_burst = ($urandom_range(0, 3) == 0);
            tx_gap = tx_burst ? 0 : $urandom_range(0, 3);
        end
    end

    // Sender: offer the next request once the gap has run out
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (!have_cur)
            begin
                if (tx_gap > 0)
                    tx_gap--;
                else if (pending_reqs.size() != 0 &&
                         (!pending_reqs[0].wait_drain || expected_bytes.size() == 0))
                begin
                    cur_req  = pending_reqs.pop_front();
                    have_cur = 1'b1;
                end
            end
            in_valid       <= have_cur;
            operation      <= cur_req.op;
            data_in        <= cur_req.data;
            end_of_message <= cur_req.eom;
        end
    end

    // Receiver: check each result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_bytes.size() == 0)
            begin
                $error("data_out: no result expected, got %02h", data_out);
                errors++;
            end
            else
            begin
                rx_exp = expected_bytes.pop_front();
                if (data_out !== rx_exp.data)
                begin
                    $error("data_out: expected %02h, got %02h", rx_exp.data, data_out);
                    errors++;
                end
                if (end_of_message_res !== rx_exp.eom)
                begin
                    $error("end_of_message_res: expected %0b, got %0b",
                           rx_exp.eom, end_of_message_res);
                    errors++;
                end
            end
            // Back up the block now and then so that the input stalls
            if (results_seen == 60 || results_seen == 500)
                rx_hold = LONG_HOLD;
            if (results_seen % 50 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
            rx_wait = rx_burst ? 0 : $urandom_range(0, 3);
        end
    end

    // Receiver: stall for the drawn wait or a long hold
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (rx_hold > 0)
        begin
            rx_hold--;
            out_stall <= 1'b1;
        end
        else if (rx_wait > 0)
        begin
            rx_wait--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Stimulus: directed phases, then random phases with fresh keys
    initial
    begin
        logic [rc4_pkg::KEY_REG_W-1:0] lo;
        logic [rc4_pkg::KEY_REG_W-1:0] hi;
        logic                          op;

        rst_n          <= 1'b0;
        cfg_write      <= 1'b0;
        cfg_index      <= rc4_pkg::REG_KEY_LOW;
        cfg_data       <= '0;
        in_valid       <= 1'b0;
        operation      <= rc4_pkg::OP_DATA;
        data_in        <= 8'h00;
        end_of_message <= 1'b0;
        out_stall      <= 1'b0;
        cur_req  = '0;
        keyed    = 1'b0;
        idx_i    = 8'd0;
        idx_j    = 8'd0;
        key_lo_m = '0;
        key_hi_m = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Pass through while unkeyed, then key from the reset registers and rekey mid-stream
        push_req(rc4_pkg::OP_DATA, 8'h00, 1'b0, 1'b0);
        push_req(rc4_pkg::OP_DATA, 8'hFF, 1'b1, 1'b0);
        push_req(rc4_pkg::OP_DATA, 8'h5A, 1'b0, 1'b0);
        push_req(rc4_pkg::OP_DATA, 8'hA5, 1'b1, 1'b0);
        push_req(rc4_pkg::OP_SCHEDULE, 8'hFF, 1'b1, 1'b0);
        push_req(rc4_pkg::OP_DATA, 8'h00, 1'b0, 1'b0);
        push_req(rc4_pkg::OP_DATA, 8'hFF, 1'b1, 1'b0);
        push_req(rc4_pkg::OP_DATA, 8'h01, 1'b0, 1'b0);
        push_req(rc4_pkg::OP_DATA, 8'h80, 1'b0, 1'b0);
        push_req(rc4_pkg::OP_DATA, 8'h7F, 1'b1, 1'b0);
        push_req(rc4_pkg::OP_SCHEDULE, 8'h00, 1'b0, 1'b0);
        push_req(rc4_pkg::OP_DATA, 8'h00, 1'b0, 1'b0);
        push_req(rc4_pkg::OP_DATA, 8'h3C, 1'b1, 1'b1);
        wait_idle();

        // All-ones key
        write_key(rc4_pkg::REG_KEY_LOW, '1);
        write_key(rc4_pkg::REG_KEY_HIGH, '1);
        @(posedge clk);
        push_req(rc4_pkg::OP_SCHEDULE, 8'h00, 1'b0, 1'b0);
        push_req(rc4_pkg::OP_DATA, 8'hFF, 1'b0, 1'b0);
        push_req(rc4_pkg::OP_DATA, 8'h00, 1'b1, 1'b0);
        push_req(rc4_pkg::OP_DATA, 8'hAA, 1'b0, 1'b0);
        wait_idle();

        // Mixed key with distinct bytes
        write_key(rc4_pkg::REG_KEY_LOW, 64'h0123_4567_89AB_CDEF);
        write_key(rc4_pkg::REG_KEY_HIGH, 64'hFEDC_BA98_7654_3210);
        @(posedge clk);
        push_req(rc4_pkg::OP_SCHEDULE, 8'h55, 1'b1, 1'b0);
        push_req(rc4_pkg::OP_DATA, 8'h12, 1'b0, 1'b0);
        push_req(rc4_pkg::OP_DATA, 8'h34, 1'b0, 1'b0);
        push_req(rc4_pkg::OP_DATA, 8'h56, 1'b1, 1'b0);
        push_req(rc4_pkg::OP_DATA, 8'hC3, 1'b0, 1'b0);
        push_req(rc4_pkg::OP_DATA, 8'hE7, 1'b1, 1'b0);
        wait_idle();

        // Random phases: rekey first, then mostly data with the odd rekey
        for (int k = 0; k < RANDOM_PHASES; k++)
        begin
            case (k % 3)
                0:
                begin
                    lo = {$urandom, $urandom};
                    hi = {$urandom, $urandom};
                end
                1:
                begin
                    lo = '0;
                    hi = '1;
                end
                default:
                begin
                    lo = '1;
                    hi = 64'h1 << $urandom_range(0, 63);
                end
            endcase
            write_key(rc4_pkg::REG_KEY_LOW, lo);
            write_key(rc4_pkg::REG_KEY_HIGH, hi);
            @(posedge clk);
            for (int n = 0; n < PHASE_REQS; n++)
            begin
                if (n == 0 || $urandom_range(0, 49) == 0)
                    op = rc4_pkg::OP_SCHEDULE;
                else
                    op = rc4_pkg::OP_DATA;
                push_req(op, 8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0),
                         (n == 40) || ($urandom_range(0, 99) == 0));
            end
            wait_idle();
        end

        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
